// File: hdl/ksgoc_pkg.sv
// Shared types and constants for the keyed slot table (get-or-create / attach).
// No dependencies. Used by ksgoc_ctrl and keyed_slot_table_get_or_create_core.
`timescale 1ns / 1ps

package ksgoc_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int KEY_W          = 32;
	localparam int PAGE_W         = 32;
	localparam int ADDR_W         = 32;
	localparam int SLOT_IN_W      = 8;
	localparam int SLOT_ID_W      = 6;
	localparam int ENTRY_W        = KEY_W + PAGE_W;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_CREATED = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_ID_W-1:0]  slot_id;
		logic [PAGE_W-1:0]     page_out;
		logic [ADDR_W-1:0]     virt_addr;
		logic [ADDR_W-1:0]     map_target;
	} result_t;

endpackage

// File: hdl/ksgoc_mem.sv
// Slot storage: one write port and one registered read port.
// Holds key and page of each slot side by side. Depends on nothing.
`timescale 1ns / 1ps

module ksgoc_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/ksgoc_ctrl.sv
// Sequencer of the slot table: takes an item, scans slots through one shared key
// comparator or reads one slot for attach, and holds the result until taken.
// Depends on ksgoc_pkg; drives the ports of ksgoc_mem.
`timescale 1ns / 1ps

module ksgoc_ctrl #(
	parameter int SLOT_COUNT = ksgoc_pkg::SLOT_COUNT_DEF,
	parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic signed [ksgoc_pkg::KEY_W-1:0]  lookup_key,
	input  logic [ksgoc_pkg::PAGE_W-1:0]      fresh_page,
	input  logic [ksgoc_pkg::SLOT_IN_W-1:0]   slot_index,
	input  logic [ksgoc_pkg::ADDR_W-1:0]      heap_top,
	input  logic [ksgoc_pkg::ADDR_W-1:0]      code_base,
	// Result toward the output register
	output logic                              res_valid,
	input  logic                              res_ready,
	output ksgoc_pkg::result_t                res,
	// Slot memory
	output logic                              mem_we,
	output logic [IDX_W-1:0]                  mem_waddr,
	output logic [ksgoc_pkg::ENTRY_W-1:0]     mem_wdata,
	output logic                              mem_re,
	output logic [IDX_W-1:0]                  mem_raddr,
	input  logic [ksgoc_pkg::ENTRY_W-1:0]     mem_rdata
);

	import ksgoc_pkg::*;

	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0]     SCAN_END = CNT_W'(SLOT_COUNT);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [SLOT_IN_W:0]   SLOT_LIM = (SLOT_IN_W + 1)'(SLOT_COUNT);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		ATT_RD,
		ATT_DATA,
		DONE
	} state_t;

	state_t                  state_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAGE_W-1:0]       page_q;
	logic [SLOT_IN_W-1:0]    idx_q;
	logic [ADDR_W-1:0]       heap_q;
	logic [ADDR_W-1:0]       base_q;
	logic [CNT_W-1:0]        addr_q;
	logic                    cmp_vld_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic                    slot_vld_s1;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [SLOT_COUNT-1:0]   valid_q;
	result_t                 res_q;

	logic                    scan_rd;
	logic                    hit;
	logic                    last_cmp;
	logic                    have_free;
	logic [IDX_W-1:0]        new_idx;
	logic                    idx_in_range;
	logic                    create;

	// The shared comparator: one stored key against the search key per cycle.
	assign scan_rd      = (state_q == SCAN) && (addr_q < SCAN_END);
	assign hit          = cmp_vld_s1 && slot_vld_s1 && (mem_rdata[KEY_W-1:0] == key_q);
	assign last_cmp     = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign have_free    = free_found_q || !slot_vld_s1;
	assign new_idx      = free_found_q ? free_idx_q : cmp_idx_s1;
	assign idx_in_range = {1'b0, idx_q} < SLOT_LIM;
	assign create       = (state_q == SCAN) && last_cmp && !hit && have_free;

	assign mem_we    = create;
	assign mem_waddr = new_idx;
	assign mem_wdata = {page_q, key_q};
	assign mem_re    = scan_rd || (state_q == ATT_RD);
	assign mem_raddr = (state_q == SCAN) ? addr_q[IDX_W-1:0] : idx_q[IDX_W-1:0];

	assign in_stall  = (state_q != IDLE);
	assign res_valid = (state_q == DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			valid_q      <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			addr_q       <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						key_q        <= lookup_key;
						page_q       <= fresh_page;
						idx_q        <= slot_index;
						heap_q       <= heap_top;
						base_q       <= code_base;
						addr_q       <= '0;
						cmp_vld_s1   <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= opcode ? ATT_RD : SCAN;
					end
				end
				SCAN: begin
					addr_q      <= addr_q + CNT_W'(1);
					cmp_vld_s1  <= scan_rd;
					cmp_idx_s1  <= addr_q[IDX_W-1:0];
					slot_vld_s1 <= scan_rd && valid_q[addr_q[IDX_W-1:0]];
					if (cmp_vld_s1 && !slot_vld_s1 && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_idx_s1;
					end
					if (hit) begin
						res_q   <= '{ST_FOUND, SLOT_ID_W'(cmp_idx_s1), '0, '0, '0};
						state_q <= DONE;
					end else if (last_cmp) begin
						if (have_free) begin
							valid_q[new_idx] <= 1'b1;
							res_q <= '{ST_CREATED, SLOT_ID_W'(new_idx), '0, '0, '0};
						end else begin
							res_q <= '{ST_FULL, '0, '0, '0, '0};
						end
						state_q <= DONE;
					end
				end
				ATT_RD: begin
					if (idx_in_range && valid_q[idx_q[IDX_W-1:0]]) begin
						state_q <= ATT_DATA;
					end else begin
						res_q   <= '{ST_INVALID, '0, '0, '0, '0};
						state_q <= DONE;
					end
				end
				ATT_DATA: begin
					res_q <= '{ST_FOUND, SLOT_ID_W'(idx_q[IDX_W-1:0]),
						mem_rdata[ENTRY_W-1:KEY_W], heap_q, heap_q + base_q};
					state_q <= DONE;
				end
				DONE: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/keyed_slot_table_get_or_create_core.sv
// Keyed slot table, get-or-create by key and attach by slot index.
// Get: one transfer in, then one slot compared per cycle through the shared
// comparator, ended early on a hit; the result then goes into the output register.
// Attach: reads the one slot in ATT_RD, takes its page in ATT_DATA. One item at a time.
// Reset (arst_n low) clears all valid marks and control state; the key and page
// memory is not cleared, and its contents are used only for valid slots.
`timescale 1ns / 1ps

module keyed_slot_table_get_or_create_core #(
	parameter int SLOT_COUNT = ksgoc_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [ksgoc_pkg::KEY_W-1:0]  lookup_key,
	input  logic [ksgoc_pkg::PAGE_W-1:0]        fresh_page,
	input  logic [ksgoc_pkg::SLOT_IN_W-1:0]     slot_index,
	input  logic [ksgoc_pkg::ADDR_W-1:0]        heap_top,
	input  logic [ksgoc_pkg::ADDR_W-1:0]        code_base,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [ksgoc_pkg::SLOT_ID_W-1:0]     slot_id,
	output logic [ksgoc_pkg::PAGE_W-1:0]        page_out,
	output logic [ksgoc_pkg::ADDR_W-1:0]        virt_addr,
	output logic [ksgoc_pkg::ADDR_W-1:0]        map_target
);

	import ksgoc_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic                res_valid;
	logic                res_ready;
	result_t             res;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [IDX_W-1:0]    mem_raddr;
	logic [ENTRY_W-1:0]  mem_rdata;
	logic                out_valid_q;
	result_t             out_q;

	ksgoc_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.fresh_page (fresh_page),
		.slot_index (slot_index),
		.heap_top   (heap_top),
		.code_base  (code_base),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ksgoc_mem #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register frees up in the same cycle its result is transferred out.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot_id    = out_q.slot_id;
	assign page_out   = out_q.page_out;
	assign virt_addr  = out_q.virt_addr;
	assign map_target = out_q.map_target;

endmodule
